/* rtl/pbqt_pkg.sv */
// Shared types, constants and helpers for the packed bitmap quarter-turn block.
`default_nettype none

package pbqt_pkg;

  localparam int WORD_W      = 16;
  localparam int LANES       = 16;
  localparam int LANE_W      = 4;
  localparam int ADDR_W      = 8;
  localparam int STORE_DEPTH = 256;
  localparam int DIM_W       = 7;
  localparam int POS_W       = 6;
  localparam int SC_W        = 9;
  localparam int WPR_W       = 3;
  localparam int COL_W       = 2;
  localparam int MODE_W      = 3;
  localparam int CFG_IDX_W   = 2;
  localparam int MAX_WIDTH   = 64;
  localparam int MAX_HEIGHT  = 64;

  localparam logic [MODE_W-1:0] MODE_ROT0   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_ROT90  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_ROT180 = 3'd2;
  localparam logic [MODE_W-1:0] MODE_ROT270 = 3'd3;
  localparam logic [MODE_W-1:0] MODE_MIRROR = 3'd4;

  // Register indexes on the cfg_ port.
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MODE   = 2'd2;

  // Request kinds carried on in_tuser.
  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_READ  = 1'b1;

  // Geometry of the destination row being built, shared by all lanes.
  typedef struct packed {
    logic [DIM_W-1:0]  w;
    logic [DIM_W-1:0]  h;
    logic [WPR_W-1:0]  wpr;
    logic [POS_W-1:0]  xc;
    logic [POS_W-1:0]  yc;
    logic [MODE_W-1:0] mode;
    logic [POS_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic              row_ok;
  } ctx_t;

  // Source pixel one lane needs: store word, bit in it, and whether it exists.
  typedef struct packed {
    logic              ok;
    logic [ADDR_W-1:0] addr;
    logic [LANE_W-1:0] bitpos;
  } lane_res_t;

  typedef struct packed {
    logic              start;
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [WORD_W-1:0] wdata;
  } gth_ctrl_t;

  typedef struct packed {
    logic              busy;
    logic [WORD_W-1:0] word;
  } gth_stat_t;

  // Exact floor(v/3) for 8-bit v via reciprocal multiply.
  function automatic logic [ADDR_W-1:0] div3(input logic [ADDR_W-1:0] v);
    logic [ADDR_W+8:0] p;
    p = {9'd0, v} * 17'd171;
    return p[ADDR_W+8:9];
  endfunction

endpackage

`default_nettype wire

/* rtl/packed_bitmap_quarter_turn.sv */
// Top level: packed bitmap store with quarter-turn and mirror readout.
//
// Usage: a one-bit bitmap lives in a 256-word store, 16 pixels per word,
// ceil(width/16) words per row. Each input word carries word_index and
// word_data in in_tdata and req_type in in_tuser. A write (req_type 0)
// stores word_data; a read (req_type 1) returns one destination word of
// the image turned by 0/90/180/270 degrees or mirrored left-right.
// Every input word yields exactly one output word (zero for writes).
// Configuration (width, height, mode) is written on the cfg_ port while
// no word is in flight; it takes effect for the next word.
// Sequence: one word is in work at a time. A write is stored when it is
// accepted and goes straight to the output state. A read decodes row and
// column word into a registered context, lets sixteen lanes compute their
// source addresses, reads the store once per pixel, waits for the registered
// read data and the end of the gather and loads the output register; the
// next word is taken once the output register has been loaded.
// The output register holds a finished word while the receiver stalls;
// the block waits in its output state until the register frees up.
// Reset restores width 16, height 16, mode 0 and empties the pipeline;
// store contents are undefined until written.
`default_nettype none

module packed_bitmap_quarter_turn import pbqt_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [23:0]          in_tdata,   // word_index[7:0], word_data[23:8]
  input  logic                 in_tuser,   // req_type
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [WORD_W-1:0]    out_tdata,  // result_word[15:0]
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_addr,
  input  logic [DIM_W-1:0]     cfg_wdata
);

  typedef enum logic [2:0] {ST_IDLE, ST_DEC, ST_LOAD, ST_RUN, ST_OUT} state_t;

  state_t                state_r, state_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [WORD_W-1:0]     out_data_r, out_data_nxt;
  logic [ADDR_W-1:0]     idx_r, idx_nxt;
  logic                  is_read_r, is_read_nxt;
  ctx_t                  ctx_r, ctx_nxt;

  logic [DIM_W-1:0]      cfg_w_r, cfg_h_r;
  logic [MODE_W-1:0]     cfg_mode_r;

  logic [DIM_W-1:0]      w_eff, h_eff;
  logic [DIM_W:0]        w_sum;
  logic [WPR_W-1:0]      wpr;
  logic [ADDR_W-1:0]     row_q, col_r3;
  logic [COL_W-1:0]      col;
  logic                  in_accept;

  gth_ctrl_t             gctrl;
  gth_stat_t             gstat;
  lane_res_t [LANES-1:0] lane_res;

  // Configuration registers; indexes past the list are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_w_r    <= DIM_W'(16);
      cfg_h_r    <= DIM_W'(16);
      cfg_mode_r <= MODE_ROT0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_WIDTH:  cfg_w_r    <= cfg_wdata;
        REG_HEIGHT: cfg_h_r    <= cfg_wdata;
        REG_MODE:   cfg_mode_r <= cfg_wdata[MODE_W-1:0];
        default: ;
      endcase
    end
  end

  // Saturate the size into 1..MAX and derive words per row.
  always_comb begin
    if (cfg_w_r == '0) begin
      w_eff = DIM_W'(1);
    end else if (cfg_w_r > DIM_W'(MAX_WIDTH)) begin
      w_eff = DIM_W'(MAX_WIDTH);
    end else begin
      w_eff = cfg_w_r;
    end
    if (cfg_h_r == '0) begin
      h_eff = DIM_W'(1);
    end else if (cfg_h_r > DIM_W'(MAX_HEIGHT)) begin
      h_eff = DIM_W'(MAX_HEIGHT);
    end else begin
      h_eff = cfg_h_r;
    end
    w_sum = {1'b0, w_eff} + (DIM_W+1)'(15);
    wpr   = WPR_W'(w_sum >> 4);
  end

  // Split the word index into destination row and column word.
  always_comb begin
    col_r3 = idx_r - (div3(idx_r) << 1) - div3(idx_r);
    case (wpr)
      3'd2: begin
        row_q = idx_r >> 1;
        col   = {1'b0, idx_r[0]};
      end
      3'd3: begin
        row_q = div3(idx_r);
        col   = col_r3[COL_W-1:0];
      end
      3'd4: begin
        row_q = idx_r >> 2;
        col   = idx_r[1:0];
      end
      default: begin
        row_q = idx_r;
        col   = '0;
      end
    endcase
  end

  assign in_tready = (state_r == ST_IDLE);
  assign in_accept = in_tvalid && in_tready;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    idx_nxt       = idx_r;
    is_read_nxt   = is_read_r;
    ctx_nxt       = ctx_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          idx_nxt     = in_tdata[ADDR_W-1:0];
          is_read_nxt = (in_tuser == REQ_READ);
          state_nxt   = (in_tuser == REQ_READ) ? ST_DEC : ST_OUT;
        end
      end
      ST_DEC: begin
        ctx_nxt.w      = w_eff;
        ctx_nxt.h      = h_eff;
        ctx_nxt.wpr    = wpr;
        ctx_nxt.xc     = w_eff[DIM_W-1:1];
        ctx_nxt.yc     = h_eff[DIM_W-1:1];
        ctx_nxt.mode   = cfg_mode_r;
        ctx_nxt.row    = row_q[POS_W-1:0];
        ctx_nxt.col    = col;
        ctx_nxt.row_ok = row_q < {1'b0, h_eff};
        state_nxt      = ST_LOAD;
      end
      ST_LOAD: begin
        state_nxt = ST_RUN;
      end
      ST_RUN: begin
        if (!gstat.busy) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        // hold the result until the output register is free
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = is_read_r ? gstat.word : '0;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_data_r <= out_data_nxt;
    idx_r      <= idx_nxt;
    is_read_r  <= is_read_nxt;
    ctx_r      <= ctx_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Sixteen lanes, one per destination bit.
  for (genvar g = 0; g < LANES; g++) begin : g_lane
    pbqt_lane u_lane (
      .ctx      (ctx_r),
      .lane_idx (LANE_W'(g)),
      .res      (lane_res[g])
    );
  end

  assign gctrl.start = (state_r == ST_LOAD);
  assign gctrl.we    = in_accept && (in_tuser == REQ_WRITE);
  assign gctrl.waddr = in_tdata[ADDR_W-1:0];
  assign gctrl.wdata = in_tdata[ADDR_W+WORD_W-1:ADDR_W];

  pbqt_gather u_gather (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (gctrl),
    .lanes (lane_res),
    .stat  (gstat)
  );

`ifndef SYNTHESIS
  a_busy_only_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    gstat.busy |-> state_r == ST_RUN)
    else $error("gather busy outside run state");

  a_load_starts_gather: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_LOAD |=> gstat.busy)
    else $error("gather did not start after load");

  a_write_goes_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && in_tuser == REQ_WRITE |=> state_r == ST_OUT && !is_read_r)
    else $error("write word did not go straight to output");
`endif

endmodule

`default_nettype wire

/* rtl/pbqt_lane.sv */
// One lane: maps a destination pixel to its source word address and bit.
`default_nettype none

module pbqt_lane import pbqt_pkg::*; (
  input  ctx_t              ctx,
  input  logic [LANE_W-1:0] lane_idx,
  output lane_res_t         res
);

  logic [POS_W-1:0]       j;
  logic signed [SC_W-1:0] jv, kv, xcv, ycv, wv, hv, dj, dk, sx, sy;
  logic                   x_ok, y_ok, j_ok;
  logic [8:0]             row_base;

  always_comb begin
    j   = {ctx.col, lane_idx};
    jv  = $signed({{(SC_W-POS_W){1'b0}}, j});
    kv  = $signed({{(SC_W-POS_W){1'b0}}, ctx.row});
    xcv = $signed({{(SC_W-POS_W){1'b0}}, ctx.xc});
    ycv = $signed({{(SC_W-POS_W){1'b0}}, ctx.yc});
    wv  = $signed({{(SC_W-DIM_W){1'b0}}, ctx.w});
    hv  = $signed({{(SC_W-DIM_W){1'b0}}, ctx.h});
    dj  = jv - xcv;
    dk  = kv - ycv;
    case (ctx.mode)
      MODE_ROT90: begin
        sx = xcv + dk;
        sy = ycv - dj;
      end
      MODE_ROT180: begin
        sx = xcv - dj;
        sy = ycv - dk;
      end
      MODE_ROT270: begin
        sx = xcv - dk;
        sy = ycv + dj;
      end
      MODE_MIRROR: begin
        sx = wv - 9'sd1 - jv;
        sy = kv;
      end
      default: begin
        sx = jv;
        sy = kv;
      end
    endcase
    j_ok = {1'b0, j} < ctx.w;
    x_ok = !sx[SC_W-1] && (sx < wv);
    y_ok = !sy[SC_W-1] && (sy < hv);
    row_base = {3'b000, sy[POS_W-1:0]} * {6'd0, ctx.wpr};
    res.ok     = ctx.row_ok & j_ok & x_ok & y_ok;
    res.addr   = row_base[ADDR_W-1:0] + {6'd0, sx[5:4]};
    res.bitpos = sx[LANE_W-1:0];
  end

endmodule

`default_nettype wire

/* rtl/pbqt_gather.sv */
// Source store plus the merge stage that reads one lane's pixel per cycle.
`default_nettype none

module pbqt_gather import pbqt_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  gth_ctrl_t              ctrl,
  input  lane_res_t [LANES-1:0]  lanes,
  output gth_stat_t              stat
);

  logic [WORD_W-1:0]     mem [STORE_DEPTH];
  lane_res_t [LANES-1:0] queue_r;
  logic                  busy_r;
  logic [LANE_W:0]       issue_cnt_r;
  logic                  take_r;
  logic                  take_ok_r;
  logic [LANE_W-1:0]     take_bit_r;
  logic [WORD_W-1:0]     rd_data_r;
  logic [WORD_W-1:0]     acc_r;
  logic                  issue;
  logic                  pix;

  assign issue = busy_r && !issue_cnt_r[LANE_W];
  assign pix   = take_ok_r & rd_data_r[take_bit_r];

  always_ff @(posedge clk) begin
    if (ctrl.we) begin
      mem[ctrl.waddr] <= ctrl.wdata;
    end
    if (issue) begin
      rd_data_r <= mem[queue_r[0].addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      issue_cnt_r <= '0;
      take_r      <= 1'b0;
    end else begin
      take_r <= issue;
      if (ctrl.start) begin
        busy_r      <= 1'b1;
        issue_cnt_r <= '0;
      end else begin
        if (issue) begin
          issue_cnt_r <= issue_cnt_r + 1'b1;
        end
        // drop busy once the last pixel lands in the word
        if (take_r && !issue) begin
          busy_r <= 1'b0;
        end
      end
    end
    if (ctrl.start) begin
      queue_r <= lanes;
    end else if (issue) begin
      queue_r <= queue_r >> $bits(lane_res_t);
    end
    if (issue) begin
      take_ok_r  <= queue_r[0].ok;
      take_bit_r <= queue_r[0].bitpos;
    end
    if (take_r) begin
      acc_r <= {pix, acc_r[WORD_W-1:1]};
    end
  end

  assign stat.busy = busy_r;
  assign stat.word = acc_r;

endmodule

`default_nettype wire
